### rtl/occupancy_grid_line_engine_macros.svh
// Assertion macros shared by the occupancy grid line engine RTL.
`ifndef OCCUPANCY_GRID_LINE_ENGINE_MACROS_SVH
`define OCCUPANCY_GRID_LINE_ENGINE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define OGLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define OGLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ogle_pkg.sv
// Types and constants of the occupancy grid line engine.
package ogle_pkg;

  typedef enum logic [2:0] {
    MODE_READ  = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_DRAW  = 3'd2,
    MODE_COUNT = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SQ0,
    S_SQ1,
    S_SQRT,
    S_SQFIX,
    S_WALK,
    S_DRAIN,
    S_FILL,
    S_DONE
  } state_t;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_TAG  = 2'd2;

  localparam logic [9:0] COLS_RESET = 10'd512;
  localparam logic [9:0] ROWS_RESET = 10'd512;
  localparam logic [7:0] TAG_RESET  = 8'd1;

  localparam logic [7:0] CODE_EMPTY   = 8'd0;
  localparam logic [7:0] CODE_BLOCKED = 8'hFF;

  localparam logic [31:0] WEIGHT_TAG   = 32'd4;
  localparam logic [31:0] WEIGHT_PLAIN = 32'd1;

  localparam logic [26:0] SQRT_BIT_TOP = 27'h400_0000;

endpackage

### rtl/ogle_ram.sv
// Generic single-port synchronous RAM with registered read.
module ogle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/occupancy_grid_line_engine.sv
// Occupancy grid line engine: cell access, line draw and count, grid clear.
//
//   port group   direction  handshake             payload
//   in           receive    in_valid / in_stall   mode x_from y_from x_to y_to code
//   out          send       out_valid / out_stall cell_code weight_sum status
//   cfg          receive    cfg_we                cfg_index cfg_data
//
// Draw line and count line walk one cell per cycle through the single grid RAM port,
// along the larger of |dx| and |dy|; count line first squares and takes a square root.
// Clear writes cols * rows entries, one RAM entry per cycle.
// After reset the grid is cleared to zero with in_stall high; configuration
// writes are taken throughout.
// A new item is taken while a finished result waits under out_stall.
`include "occupancy_grid_line_engine_macros.svh"

module occupancy_grid_line_engine #(
  parameter int GRID_COLS = 512,
  parameter int GRID_ROWS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [12:0] x_from,
  input  logic signed [12:0] y_from,
  input  logic signed [12:0] x_to,
  input  logic signed [12:0] y_to,
  input  logic [7:0]         code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         cell_code,
  output logic [31:0]        weight_sum,
  output logic               status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  import ogle_pkg::*;

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  logic [9:0] cols_in_use;
  logic [9:0] rows_in_use;
  logic [7:0] tag_code;
  logic [9:0] eff_cols;
  logic [9:0] eff_rows;

  state_t state;
  state_t state_next;

  mode_t       mode_r;
  logic [7:0]  code_r;
  logic [12:0] sx;
  logic [12:0] sy;
  logic [12:0] n;
  logic [12:0] dabs;
  logic        neg;
  logic        xmajor;
  logic [12:0] adx_r;
  logic [12:0] ady_r;
  logic [12:0] k;
  logic [12:0] q;
  logic [12:0] acc;
  logic [31:0] sum;
  logic [7:0]  cell_val;
  logic        miss;

  logic [CW-1:0] fill_cnt;
  logic [CW-1:0] fill_end;
  logic [7:0]    fill_val;
  logic          fill_active;
  logic          fill_we;

  logic [27:0] sq_n;
  logic [27:0] sq_m;
  logic [27:0] sq_r;
  logic [26:0] sq_bit;
  logic [27:0] sq_trial;
  logic [15:0] weight_w;
  logic [13:0] mul_op;
  logic [27:0] mul_p;

  logic          v_a;
  logic          v_b;
  logic          v_c;
  logic [14:0]   cx_a;
  logic [14:0]   cy_a;
  logic          ok_a;
  logic          ok_b;
  logic          ok_c;
  logic [AW-1:0] addr_b;
  logic [19:0]   lin;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic        in_fire;
  logic        out_load;
  logic [13:0] dx;
  logic [13:0] dy;
  logic [12:0] adx;
  logic [12:0] ady;
  logic        set_xmajor;
  logic        set_neg;
  logic [12:0] set_sx;
  logic [12:0] set_sy;
  logic [12:0] set_n;
  logic [12:0] set_dabs;
  logic [19:0] grid_cells;

  logic [13:0] off;
  logic [14:0] off15;
  logic [14:0] sx15;
  logic [14:0] sy15;
  logic [14:0] k15;
  logic [14:0] cx_w;
  logic [14:0] cy_w;
  logic [13:0] acc_sum;
  logic        acc_wrap;

  logic [7:0]  cell_rd;
  logic [31:0] add_w;
  logic [32:0] sum_ext;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
      tag_code    <= TAG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_in_use <= cfg_data;
        CFG_ROWS: rows_in_use <= cfg_data;
        CFG_TAG:  tag_code    <= cfg_data[7:0];
        default:  ;
      endcase
    end
  end

  assign eff_cols = (32'(cols_in_use) > GRID_COLS) ? 10'(GRID_COLS) : cols_in_use;
  assign eff_rows = (32'(rows_in_use) > GRID_ROWS) ? 10'(GRID_ROWS) : rows_in_use;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // line setup
  assign dx  = {x_to[12], x_to} - {x_from[12], x_from};
  assign dy  = {y_to[12], y_to} - {y_from[12], y_from};
  assign adx = dx[13] ? 13'(-dx) : dx[12:0];
  assign ady = dy[13] ? 13'(-dy) : dy[12:0];
  assign grid_cells = 20'(eff_cols) * 20'(eff_rows);

  always_comb begin
    set_sx     = x_from;
    set_sy     = y_from;
    set_n      = '0;
    set_dabs   = '0;
    set_neg    = 1'b0;
    set_xmajor = 1'b1;
    if (mode == MODE_DRAW || mode == MODE_COUNT) begin
      if (dx == '0 || dy == '0) begin
        set_xmajor = (dx != '0);
        if (dx != '0) begin
          if (dx[13]) begin
            set_sx = x_to;
          end
          set_n = adx;
        end else begin
          if (dy[13]) begin
            set_sy = y_to;
          end
          set_n = ady;
        end
      end else if (adx > ady) begin
        if (dx[13]) begin
          set_sx = x_to;
          set_sy = y_to;
        end
        set_n    = adx;
        set_dabs = ady;
        set_neg  = dx[13] ? !dy[13] : dy[13];
      end else begin
        set_xmajor = 1'b0;
        if (dy[13]) begin
          set_sx = x_to;
          set_sy = y_to;
        end
        set_n    = ady;
        set_dabs = adx;
        set_neg  = dy[13] ? !dx[13] : dx[13];
      end
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (fill_cnt == fill_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_READ, MODE_WRITE, MODE_DRAW: state_next = S_WALK;
            MODE_COUNT: state_next = S_SQ0;
            MODE_CLEAR: state_next = S_FILL;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_SQ0:   state_next = S_SQ1;
      S_SQ1:   state_next = S_SQRT;
      S_SQRT: begin
        if (sq_bit == 27'd1) state_next = S_SQFIX;
      end
      S_SQFIX: state_next = S_WALK;
      S_WALK: begin
        if (k == n) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!v_a && !v_b && !v_c) state_next = S_DONE;
      end
      S_FILL: begin
        if (fill_cnt == fill_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // shared squaring multiplier
  always_comb begin
    case (state)
      S_SQ0:   mul_op = {1'b0, adx_r};
      S_SQ1:   mul_op = {1'b0, ady_r};
      S_SQFIX: mul_op = sq_r[13:0];
      default: mul_op = '0;
    endcase
  end
  assign mul_p    = 28'(mul_op) * 28'(mul_op);
  assign sq_trial = sq_r + 28'(sq_bit);

  // line walk step
  assign off      = neg ? -{1'b0, q} : {1'b0, q};
  assign off15    = {off[13], off};
  assign sx15     = {{2{sx[12]}}, sx};
  assign sy15     = {{2{sy[12]}}, sy};
  assign k15      = {2'b00, k};
  assign cx_w     = xmajor ? sx15 + k15 : sx15 + off15;
  assign cy_w     = xmajor ? sy15 + off15 : sy15 + k15;
  assign acc_sum  = {1'b0, acc} + {1'b0, dabs};
  assign acc_wrap = (acc_sum >= {1'b0, n});

  assign ok_a = !cx_a[14] && !cy_a[14] &&
                (cx_a[13:0] < {4'b0, eff_cols}) && (cy_a[13:0] < {4'b0, eff_rows});
  assign lin  = 20'(cy_a[9:0]) * 20'(eff_cols) + 20'(cx_a[9:0]);

  // count weights
  assign cell_rd = ok_c ? ram_rdata : CODE_BLOCKED;
  always_comb begin
    if (cell_rd == CODE_BLOCKED) begin
      add_w = 32'(weight_w);
    end else if (cell_rd == CODE_EMPTY) begin
      add_w = '0;
    end else if (cell_rd == tag_code) begin
      add_w = WEIGHT_TAG;
    end else begin
      add_w = WEIGHT_PLAIN;
    end
  end
  assign sum_ext = {1'b0, sum} + {1'b0, add_w};

  // grid RAM port
  assign fill_active = (state == S_CLR) || (state == S_FILL);
  assign fill_we     = fill_active && (fill_cnt != fill_end);
  assign ram_we      = fill_we ||
                       (v_b && ok_b && (mode_r == MODE_WRITE || mode_r == MODE_DRAW));
  assign ram_addr    = fill_active ? fill_cnt[AW-1:0] : addr_b;
  assign ram_wdata   = fill_active ? fill_val : code_r;

  ogle_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      out_valid <= 1'b0;
      fill_cnt  <= '0;
      fill_end  <= CW'(DEPTH);
      fill_val  <= CODE_EMPTY;
    end else begin
      v_a <= (state == S_WALK);
      v_b <= v_a;
      v_c <= v_b && (mode_r == MODE_READ || mode_r == MODE_WRITE || mode_r == MODE_COUNT);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        fill_cnt <= '0;
        fill_end <= CW'(grid_cells);
        fill_val <= code;
      end else if (fill_we) begin
        fill_cnt <= fill_cnt + CW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= mode_t'(mode);
      code_r <= code;
      sx     <= set_sx;
      sy     <= set_sy;
      n      <= set_n;
      dabs   <= set_dabs;
      neg    <= set_neg;
      xmajor <= set_xmajor;
      adx_r  <= adx;
      ady_r  <= ady;
      k      <= '0;
      q      <= '0;
      acc    <= '0;
      sum    <= '0;
      miss   <= 1'b0;
      cell_val <= CODE_EMPTY;
    end
    case (state)
      S_SQ0: sq_n <= mul_p;
      S_SQ1: begin
        sq_n   <= sq_n + mul_p;
        sq_m   <= sq_n + mul_p;
        sq_r   <= '0;
        sq_bit <= SQRT_BIT_TOP;
      end
      S_SQRT: begin
        if (sq_m >= sq_trial) begin
          sq_m <= sq_m - sq_trial;
          sq_r <= (sq_r >> 1) + 28'(sq_bit);
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_SQFIX: begin
        weight_w <= {1'b0, sq_r[13:0] + 14'(mul_p < sq_n), 1'b0};
      end
      S_WALK: begin
        if (k != n) begin
          k <= k + 13'd1;
          if (acc_wrap) begin
            acc <= 13'(acc_sum - {1'b0, n});
            q   <= q + 13'd1;
          end else begin
            acc <= acc_sum[12:0];
          end
        end
      end
      default: ;
    endcase
    cx_a   <= cx_w;
    cy_a   <= cy_w;
    ok_b   <= ok_a;
    addr_b <= AW'(lin);
    ok_c   <= ok_b;
    if (v_c) begin
      cell_val <= cell_rd;
      miss     <= !ok_c;
      if (mode_r == MODE_COUNT) begin
        sum <= sum_ext[32] ? '1 : sum_ext[31:0];
      end
    end
    if (out_load) begin
      cell_code  <= (mode_r == MODE_READ) ? cell_val : CODE_EMPTY;
      weight_sum <= (mode_r == MODE_COUNT) ? sum : '0;
      status     <= (mode_r == MODE_WRITE) ? miss : 1'b0;
    end
  end

  `OGLE_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "input taken while busy")
  `OGLE_ASSERT_NOW(a_walk_bound, state == S_WALK, k <= n, "walk step past line end")
  `OGLE_ASSERT_NOW(a_acc_bound, state == S_WALK && n != '0, acc < n, "minor remainder overflow")
  `OGLE_ASSERT_NOW(a_done_drained, state == S_DONE, !v_a && !v_b && !v_c, "result before drain")

endmodule
